// ----- sv/nfr_pkg.sv -----
// Shared types, constants and controller codes for the nondominated front ranker.
package nfr_pkg;

   // Default sizing of the block
   localparam int DEF_MAX_SOLUTIONS  = 64;
   localparam int DEF_MAX_OBJECTIVES = 8;
   localparam int DEF_VALUE_WIDTH    = 32;

   // Fixed field widths of the item ports
   localparam int OBJ_VALUE_W   = 32;
   localparam int SOL_INDEX_W   = 6;
   localparam int FRONT_RANK_W  = 6;
   localparam int FRONT_COUNT_W = 7;

   // Objective count register
   localparam int         CSR_W     = 4;
   localparam logic [3:0] CSR_RESET = 4'd2;

   typedef struct packed {
      logic signed [OBJ_VALUE_W-1:0] objective_value;
      logic                          last_value;
   } req_item_type;

   typedef struct packed {
      logic [SOL_INDEX_W-1:0]   solution_index;
      logic [FRONT_RANK_W-1:0]  front_rank;
      logic [FRONT_COUNT_W-1:0] front_count;
      logic                     overflow;
      logic                     last_result;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIV,
      ST_LEX_SCAN,
      ST_LEX_SETTLE,
      ST_ORD_READ,
      ST_ORD_LATCH,
      ST_RANK_SCAN,
      ST_RANK_SETTLE,
      ST_OUT_READ,
      ST_OUT_EMIT
   } nfr_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic div_step;
      logic div_finish;
      logic clear_set;
      logic sweep_init;
      logic scan;
      logic settle;
      logic mode_rank;
      logic ord_latch;
      logic out_read;
      logic out_emit;
   } nfr_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
      logic n_zero;
      logic k_last;
      logic b_last;
      logic a_last;
   } nfr_status_type;

endpackage

// ----- sv/nondominated_front_ranker_unit.sv -----
// Top level of the nondominated front ranker: controller plus datapath.
//
// Usage: objective values arrive one per item, solution by solution, on
// req_item while start is high and busy is low; req_item.last_value marks the
// final value of a data set; busy stays low during loading. csr_wr_en/csr_wr_data set
// the objective count m. After the final value busy rises while the block ranks
// n solutions: it counts the solutions by repeated subtraction, orders them in a
// lexicographic pass, ranks them in a ranking pass, and then reads each result
// item's rank and emits it. The pairwise compare unit walks one objective per
// cycle through two copies of the value store.
// Each result item is shown on rsp_item for one cycle with rsp_valid high,
// in solution order; the receiver cannot stall and must take every item.
// busy falls after the last result item. A final value with no complete
// solution gives no result item. Reset clears the load count and the drop
// flag and sets the objective count to 2.
module nondominated_front_ranker_unit import nfr_pkg::*; #(
   parameter int MAX_SOLUTIONS  = DEF_MAX_SOLUTIONS,
   parameter int MAX_OBJECTIVES = DEF_MAX_OBJECTIVES,
   parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   nfr_cmd_type    cmd;
   nfr_status_type status;

   nfr_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .last_value(req_item.last_value), .status(status), .busy(busy), .cmd(cmd)
   );

   nfr_datapath #(
      .MAX_SOLUTIONS(MAX_SOLUTIONS), .MAX_OBJECTIVES(MAX_OBJECTIVES),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_item(req_item), .cmd(cmd), .status(status), .rsp_item(rsp_item)
   );

   assign rsp_valid = cmd.out_emit;

endmodule

// ----- sv/nfr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module nfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/nfr_controller.sv -----
// Sequencer for load, solution count, lexicographic pass, ranking pass and output.
module nfr_controller import nfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           last_value,
   input  nfr_status_type status,
   output logic           busy,
   output nfr_cmd_type    cmd
);

   nfr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && last_value) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = status.n_zero ? ST_LOAD : ST_LEX_SCAN;
         end
         ST_LEX_SCAN: begin
            if (status.k_last) state_in = ST_LEX_SETTLE;
         end
         ST_LEX_SETTLE: begin
            if (status.b_last && status.a_last) state_in = ST_ORD_READ;
            else state_in = ST_LEX_SCAN;
         end
         ST_ORD_READ:  state_in = ST_ORD_LATCH;
         ST_ORD_LATCH: state_in = ST_RANK_SCAN;
         ST_RANK_SCAN: begin
            if (status.k_last) state_in = ST_RANK_SETTLE;
         end
         ST_RANK_SETTLE: begin
            if (status.b_last) state_in = status.a_last ? ST_OUT_READ : ST_ORD_READ;
            else state_in = ST_RANK_SCAN;
         end
         ST_OUT_READ: state_in = ST_OUT_EMIT;
         ST_OUT_EMIT: begin
            state_in = status.a_last ? ST_LOAD : ST_OUT_READ;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIV: begin
            cmd.div_step   = !status.div_done;
            cmd.clear_set  = status.div_done && status.n_zero;
            cmd.div_finish = status.div_done && !status.n_zero;
            cmd.sweep_init = status.div_done && !status.n_zero;
         end
         ST_LEX_SCAN:    cmd.scan = 1'b1;
         ST_LEX_SETTLE:  cmd.settle = 1'b1;
         ST_ORD_READ:    cmd.mode_rank = 1'b1;
         ST_ORD_LATCH: begin
            cmd.mode_rank = 1'b1;
            cmd.ord_latch = 1'b1;
         end
         ST_RANK_SCAN: begin
            cmd.mode_rank = 1'b1;
            cmd.scan      = 1'b1;
         end
         ST_RANK_SETTLE: begin
            cmd.mode_rank = 1'b1;
            cmd.settle    = 1'b1;
         end
         ST_OUT_READ: cmd.out_read = 1'b1;
         ST_OUT_EMIT: begin
            cmd.out_emit  = 1'b1;
            cmd.clear_set = status.a_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/nfr_datapath.sv -----
// Value store, counters, pairwise compare unit, order and rank tables.
module nfr_datapath import nfr_pkg::*; #(
   parameter int MAX_SOLUTIONS  = DEF_MAX_SOLUTIONS,
   parameter int MAX_OBJECTIVES = DEF_MAX_OBJECTIVES,
   parameter int VALUE_WIDTH    = DEF_VALUE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   input  req_item_type     req_item,
   input  nfr_cmd_type      cmd,
   output nfr_status_type   status,
   output rsp_item_type     rsp_item
);

   localparam int DEPTH = MAX_SOLUTIONS * MAX_OBJECTIVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int VC_W  = $clog2(DEPTH + 1);
   localparam int SOL_W = $clog2(MAX_SOLUTIONS);
   localparam int N_W   = SOL_W + 1;
   localparam int K_W   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
   localparam int M_W   = $clog2(MAX_OBJECTIVES + 1);

   logic [CSR_W-1:0] csr_ff;
   logic [VC_W-1:0]  count_ff, rem_ff;
   logic             drop_ff;
   logic [N_W-1:0]   n_ff;
   logic [SOL_W-1:0] a_ff, b_ff, q_ff, cnt_ff, best_ff, hi_ff;
   logic [K_W-1:0]   k_ff;
   logic             lex_dec_ff, lex_lt_ff, gt_ff, lt_ff, rd_vld_ff;

   logic [M_W-1:0]         m_eff;
   logic [VC_W-1:0]        cap;
   logic                   store_ok;
   logic [VC_W-1:0]        count_next;
   logic [VALUE_WIDTH-1:0] key;
   logic [SOL_W-1:0]       tgt, n_last;
   logic [AW-1:0]          p_addr, q_addr;
   logic [VALUE_WIDTH-1:0] p_rd, q_rd;
   logic signed [VALUE_WIDTH-1:0] x, y;
   logic                   lex_lt_fin, dom_fin;
   logic [SOL_W-1:0]       cnt_fin, best_fin, cand;
   logic [SOL_W-1:0]       ord_rd, rank_rd, rank_addr;
   logic                   ord_we, rank_we;

   // Objective count in use
   always_comb begin
      if (csr_ff == '0) m_eff = M_W'(1);
      else if (int'(csr_ff) > MAX_OBJECTIVES) m_eff = M_W'(MAX_OBJECTIVES);
      else m_eff = M_W'(csr_ff);
   end

   assign cap        = VC_W'(MAX_SOLUTIONS) * VC_W'(m_eff);
   assign store_ok   = count_ff < cap;
   assign count_next = store_ok ? count_ff + VC_W'(1) : count_ff;
   assign key        = VALUE_WIDTH'(req_item.objective_value);

   // Pair addressing: b is the candidate dominator, tgt the solution under test
   assign tgt    = cmd.mode_rank ? q_ff : a_ff;
   assign n_last = SOL_W'(n_ff - N_W'(1));
   assign p_addr = AW'(AW'(b_ff) * AW'(m_eff) + AW'(k_ff));
   assign q_addr = AW'(AW'(tgt) * AW'(m_eff) + AW'(k_ff));

   // Two copies of the value store give both operands in the same cycle
   nfr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_p (
      .clock(clock), .wr_en(cmd.load && store_ok), .wr_addr(count_ff[AW-1:0]),
      .wr_data(key), .rd_addr(p_addr), .rd_data(p_rd)
   );
   nfr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_q (
      .clock(clock), .wr_en(cmd.load && store_ok), .wr_addr(count_ff[AW-1:0]),
      .wr_data(key), .rd_addr(q_addr), .rd_data(q_rd)
   );

   assign x = $signed(p_rd);
   assign y = $signed(q_rd);

   // Final pair verdict, folding in the last objective
   assign lex_lt_fin = lex_dec_ff ? lex_lt_ff : ((x != y) ? (x < y) : (b_ff < tgt));
   assign dom_fin    = !(gt_ff || (x > y)) && (lt_ff || (x < y));
   assign cnt_fin    = cnt_ff + SOL_W'(lex_lt_fin);
   assign cand       = SOL_W'({1'b0, rank_rd} + {1'b0, SOL_W'(1)});
   assign best_fin   = (dom_fin && (cand > best_ff)) ? cand : best_ff;

   // Lexicographic position to solution table
   assign ord_we = cmd.settle && status.b_last && !cmd.mode_rank;
   nfr_ram #(.WIDTH(SOL_W), .DEPTH(MAX_SOLUTIONS)) u_ord (
      .clock(clock), .wr_en(ord_we), .wr_addr(cnt_fin), .wr_data(a_ff),
      .rd_addr(a_ff), .rd_data(ord_rd)
   );

   // Front rank per solution
   assign rank_we   = cmd.settle && status.b_last && cmd.mode_rank;
   assign rank_addr = cmd.out_read ? a_ff : b_ff;
   nfr_ram #(.WIDTH(SOL_W), .DEPTH(MAX_SOLUTIONS)) u_rank (
      .clock(clock), .wr_en(rank_we), .wr_addr(q_ff), .wr_data(best_fin),
      .rd_addr(rank_addr), .rd_data(rank_rd)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff    <= CSR_RESET;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (csr_wr_en) csr_ff <= csr_wr_data;
         if (cmd.load) begin
            count_ff <= count_next;
            if (!store_ok) drop_ff <= 1'b1;
         end
         if (cmd.div_finish && (rem_ff != '0)) drop_ff <= 1'b1;
         if (cmd.clear_set) begin
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end
      end
   end

   // Counters and compare accumulators
   always_ff @(posedge clock) begin
      if (cmd.load && req_item.last_value) begin
         rem_ff <= count_next;
         n_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ff - VC_W'(m_eff);
         n_ff   <= n_ff + N_W'(1);
      end
      if (cmd.sweep_init) begin
         a_ff    <= '0;
         b_ff    <= '0;
         k_ff    <= '0;
         cnt_ff  <= '0;
         best_ff <= '0;
         hi_ff   <= '0;
      end
      if (cmd.sweep_init || cmd.settle) begin
         lex_dec_ff <= 1'b0;
         lex_lt_ff  <= 1'b0;
         gt_ff      <= 1'b0;
         lt_ff      <= 1'b0;
      end
      if (cmd.scan) begin
         k_ff <= k_ff + K_W'(1);
         if (rd_vld_ff) begin
            if (!lex_dec_ff && (x != y)) begin
               lex_dec_ff <= 1'b1;
               lex_lt_ff  <= x < y;
            end
            if (x > y) gt_ff <= 1'b1;
            if (x < y) lt_ff <= 1'b1;
         end
      end
      if (cmd.settle) begin
         k_ff <= '0;
         if (status.b_last) begin
            b_ff    <= '0;
            a_ff    <= status.a_last ? '0 : a_ff + SOL_W'(1);
            cnt_ff  <= '0;
            best_ff <= '0;
            if (cmd.mode_rank && (best_fin > hi_ff)) hi_ff <= best_fin;
         end else begin
            b_ff    <= b_ff + SOL_W'(1);
            cnt_ff  <= cnt_fin;
            best_ff <= best_fin;
         end
      end
      if (cmd.ord_latch) q_ff <= ord_rd;
      if (cmd.out_emit) a_ff <= status.a_last ? '0 : a_ff + SOL_W'(1);
   end

   // Status
   assign status.div_done = (rem_ff < VC_W'(m_eff)) || (n_ff == N_W'(MAX_SOLUTIONS));
   assign status.n_zero   = n_ff == '0;
   assign status.k_last   = k_ff == K_W'(m_eff - M_W'(1));
   assign status.b_last   = b_ff == n_last;
   assign status.a_last   = a_ff == n_last;

   // Result item
   assign rsp_item.solution_index = SOL_INDEX_W'(a_ff);
   assign rsp_item.front_rank     = FRONT_RANK_W'(rank_rd);
   assign rsp_item.front_count    = FRONT_COUNT_W'({1'b0, hi_ff} + {1'b0, SOL_W'(1)});
   assign rsp_item.overflow       = drop_ff;
   assign rsp_item.last_result    = status.a_last;

endmodule

// ----- sv/nfr_checker.sv -----
// Port level checks for the ranker and the bind that attaches them.
module nfr_port_checks import nfr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // Reset leaves the block ready to load
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   // Results only appear while ranking
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result item while not busy");

   // A value that is not final keeps the block loading
   a_load_stays: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_item.last_value |=> !busy)
      else $error("busy after a non-final value");

   // Last result item ends the data set
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_result |=> !busy && !rsp_valid)
      else $error("still busy after last result item");

   // Result items never come back to back
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_result |=> !rsp_valid)
      else $error("result items back to back");

endmodule

bind nondominated_front_ranker_unit nfr_port_checks u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
